[sv/rsdt_pkg.sv]
// ----------------------------------------------------------------------------
// rsdt_pkg
// Shared types and constants for the RTP source discovery table.
// ----------------------------------------------------------------------------
package rsdt_pkg;

   localparam int OUTCOME_W = 3;
   localparam int ENTRY_W   = 6;
   localparam int COUNT_W   = 32;
   localparam int PT_W      = 7;
   localparam int TIME_W    = 64;
   localparam int IP_W      = 32;
   localparam int PORT_W    = 16;
   localparam int NEED_W    = 19;
   localparam int KEY_W     = IP_W + PORT_W;

   localparam int HDR_MIN   = 12;
   localparam logic [7:0] VER_MASK = 8'hC0;
   localparam logic [7:0] VER_TWO  = 8'h80;
   localparam logic [3:0] MC_PREFIX = 4'hE;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OUTCOME_W-1:0] OUT_NEW      = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_BAD_HDR  = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_MC_FILT  = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_UC_FILT  = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd5;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOW_MC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOW_UC = 1'd1;

   typedef struct packed {
      logic              is_clear;
      logic              ok;
      logic              mc;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] now;
      logic [PT_W-1:0]   ptype;
   } job_type;

   typedef struct packed {
      logic [PT_W-1:0]    ptype;
      logic               mc;
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  first;
   } entry_data_type;

   typedef struct packed {
      logic full;
      logic busy;
   } back_status_type;

endpackage

[sv/rsdt_if.sv]
// ----------------------------------------------------------------------------
// rsdt_if
// Request and response channels of the RTP source discovery table.
// ----------------------------------------------------------------------------
interface rsdt_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  packet_byte;
   logic        last_byte;
   logic [31:0] source_ip;
   logic [15:0] listen_port;
   logic [63:0] now_ms;

   modport source(output valid, action, packet_byte, last_byte, source_ip,
                  listen_port, now_ms, input ready);
   modport sink(input valid, action, packet_byte, last_byte, source_ip,
                listen_port, now_ms, output ready);
endinterface

interface rsdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  outcome;
   logic [5:0]  entry_index;
   logic [31:0] source_count;
   logic [6:0]  rtp_type;
   logic        is_multicast;
   logic [63:0] first_seen_ms;

   modport source(output valid, outcome, entry_index, source_count, rtp_type,
                  is_multicast, first_seen_ms, input ready);
   modport sink(input valid, outcome, entry_index, source_count, rtp_type,
                is_multicast, first_seen_ms, output ready);
endinterface

[sv/rtp_source_discovery_table_core.sv]
// ----------------------------------------------------------------------------
// rtp_source_discovery_table_core
// RTP header check and (source, port) discovery table.
// ----------------------------------------------------------------------------
// Packet bytes are taken one per cycle while the job queue has room; a
// result appears only for a packet's last byte. Each packet end or clear
// becomes a job in a two-entry queue; the table engine settles a clear,
// bad header or filtered job as it pops it, and otherwise walks the key RAM
// one entry at a time (S_READ, then S_CMP) until a hit or, after all stored
// entries, a new/full outcome. A new job is started only once the previous
// result has been accepted. A scan of a large table can outlast a short
// packet; once two jobs wait in the queue, input is held off until the
// engine pops one. No clearing pass is needed after reset.
module rtp_source_discovery_table_core #(
   parameter int MAX_SOURCES      = 64,
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   rsdt_req_if.sink                          req_bus,
   rsdt_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [rsdt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic                              csr_wr_data
);
   import rsdt_pkg::*;

   logic            allow_mc_ff, allow_uc_ff;
   logic            take, job_valid, q_valid, q_full, q_pop;
   job_type         job, q_head;
   back_status_type status;

   assign req_bus.ready = !q_full;
   assign take          = req_bus.valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_mc_ff <= 1'b1;
         allow_uc_ff <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ALLOW_MC: allow_mc_ff <= csr_wr_data;
            REG_ALLOW_UC: allow_uc_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   rsdt_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
      .clock(clock), .reset(reset), .take(take),
      .action(req_bus.action), .packet_byte(req_bus.packet_byte),
      .last_byte(req_bus.last_byte), .source_ip(req_bus.source_ip),
      .listen_port(req_bus.listen_port), .now_ms(req_bus.now_ms),
      .job_valid(job_valid), .job(job)
   );

   rsdt_queue u_queue (
      .clock(clock), .reset(reset), .push(job_valid), .push_data(job),
      .pop(q_pop), .not_empty(q_valid), .full(q_full), .head(q_head)
   );

   rsdt_back #(.MAX_SOURCES(MAX_SOURCES)) u_back (
      .clock(clock), .reset(reset), .allow_mc(allow_mc_ff), .allow_uc(allow_uc_ff),
      .job_valid(q_valid), .job(q_head), .job_pop(q_pop), .status(status),
      .rsp(rsp_bus)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full && !q_pop |-> !job_valid)
      else $error("job pushed into full queue");

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && !rsp_bus.valid)
      else $error("job popped while empty or result pending");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.outcome <= OUT_FULL)
      else $error("undefined outcome code");

   a_full_outcome: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) && rsp_bus.outcome == OUT_FULL |-> status.full)
      else $error("table full reported with free slots");
`endif
endmodule

[sv/rsdt_ram.sv]
// ----------------------------------------------------------------------------
// rsdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/rsdt_front.sv]
// ----------------------------------------------------------------------------
// rsdt_front
// Byte-wise RTP header parser; emits one job per packet end or clear.
// ----------------------------------------------------------------------------
module rsdt_front #(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic              action,
   input  logic [7:0]        packet_byte,
   input  logic              last_byte,
   input  logic [31:0]       source_ip,
   input  logic [15:0]       listen_port,
   input  logic [63:0]       now_ms,
   output logic              job_valid,
   output rsdt_pkg::job_type job
);
   import rsdt_pkg::*;

   localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
   localparam int PW = NEED_W + 1;

   logic [CW-1:0]     count_ff, count_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              ver_ff, ver_in;
   logic              ext_ff, ext_in;
   logic [PT_W-1:0]   ptype_ff, ptype_in;
   logic [7:0]        exthi_ff, exthi_in;

   logic [CW-1:0]     cnt_n;
   logic [NEED_W-1:0] need_n;
   logic              ver_n, ext_n;
   logic [PT_W-1:0]   ptype_n;
   logic [7:0]        exthi_n;
   logic [PW-1:0]     pos_w, need_w;

   always_comb begin
      cnt_n   = count_ff;
      need_n  = need_ff;
      ver_n   = ver_ff;
      ext_n   = ext_ff;
      ptype_n = ptype_ff;
      exthi_n = exthi_ff;
      pos_w   = PW'(count_ff);
      need_w  = PW'(need_ff);
      if (count_ff < CW'(MAX_PACKET_BYTES)) begin
         if (count_ff == '0) begin
            ver_n  = (packet_byte & VER_MASK) == VER_TWO;
            ext_n  = packet_byte[4];
            need_n = NEED_W'(HDR_MIN) + NEED_W'({packet_byte[3:0], 2'b00});
         end else if (count_ff == CW'(1)) begin
            ptype_n = packet_byte[PT_W-1:0];
         end
         if (pos_w >= PW'(2) && ext_ff) begin
            if (pos_w == need_w + PW'(2)) begin
               exthi_n = packet_byte;
            end else if (pos_w == need_w + PW'(3)) begin
               need_n = need_ff + NEED_W'(4)
                        + NEED_W'({exthi_ff, packet_byte, 2'b00});
               ext_n  = 1'b0;
            end
         end
         cnt_n = count_ff + CW'(1);
      end
   end

   always_comb begin
      job.is_clear = action;
      job.ok       = ver_n && cnt_n >= CW'(HDR_MIN) && !ext_n
                     && PW'(need_n) <= PW'(cnt_n);
      job.mc       = source_ip[31:28] == MC_PREFIX;
      job.ip       = source_ip;
      job.port     = listen_port;
      job.now      = now_ms;
      job.ptype    = ptype_n;
      job_valid    = take && (action || last_byte);

      count_in = count_ff;
      need_in  = need_ff;
      ver_in   = ver_ff;
      ext_in   = ext_ff;
      ptype_in = ptype_ff;
      exthi_in = exthi_ff;
      if (take) begin
         if (action || last_byte) begin
            count_in = '0;
            need_in  = NEED_W'(HDR_MIN);
            ver_in   = 1'b0;
            ext_in   = 1'b0;
            ptype_in = '0;
            exthi_in = '0;
         end else begin
            count_in = cnt_n;
            need_in  = need_n;
            ver_in   = ver_n;
            ext_in   = ext_n;
            ptype_in = ptype_n;
            exthi_in = exthi_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         need_ff  <= NEED_W'(HDR_MIN);
         ver_ff   <= 1'b0;
         ext_ff   <= 1'b0;
         ptype_ff <= '0;
         exthi_ff <= '0;
      end else begin
         count_ff <= count_in;
         need_ff  <= need_in;
         ver_ff   <= ver_in;
         ext_ff   <= ext_in;
         ptype_ff <= ptype_in;
         exthi_ff <= exthi_in;
      end
   end
endmodule

[sv/rsdt_queue.sv]
// ----------------------------------------------------------------------------
// rsdt_queue
// Short job queue between parser and table engine.
// ----------------------------------------------------------------------------
module rsdt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsdt_pkg::job_type push_data,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output rsdt_pkg::job_type head
);
   import rsdt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign not_empty = cnt_ff != '0;
   assign full      = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

[sv/rsdt_back.sv]
// ----------------------------------------------------------------------------
// rsdt_back
// Table engine: clears the table, or filters a job, scans the source table, updates or appends.
// ----------------------------------------------------------------------------
module rsdt_back #(
   parameter int MAX_SOURCES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      allow_mc,
   input  logic                      allow_uc,
   input  logic                      job_valid,
   input  rsdt_pkg::job_type         job,
   output logic                      job_pop,
   output rsdt_pkg::back_status_type status,
   rsdt_rsp_if.source                rsp
);
   import rsdt_pkg::*;

   localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int SW = $clog2(MAX_SOURCES + 1);
   localparam int DW = $bits(entry_data_type);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [SW-1:0]  idx_ff, idx_in, used_ff, used_in;
   job_type        job_ff, job_in;

   logic           key_we, data_we;
   logic [AW-1:0]  wr_addr;
   logic [KEY_W-1:0] key_wd, key_rd;
   entry_data_type data_wd, data_rd;

   logic           produce;
   logic [OUTCOME_W-1:0] r_outcome;
   logic [SW-1:0]  r_index;
   logic [COUNT_W-1:0] r_count;
   logic [PT_W-1:0] r_ptype;
   logic           r_mc;
   logic [TIME_W-1:0] r_first;

   logic           rsp_valid_ff;
   logic [OUTCOME_W-1:0] outcome_ff;
   logic [ENTRY_W-1:0] index_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [PT_W-1:0] ptype_ff;
   logic           mc_ff;
   logic [TIME_W-1:0] first_ff;

   rsdt_ram #(.WIDTH(KEY_W), .DEPTH(MAX_SOURCES)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(wr_addr), .wr_data(key_wd),
      .rd_addr(idx_ff[AW-1:0]), .rd_data(key_rd)
   );

   rsdt_ram #(.WIDTH(DW), .DEPTH(MAX_SOURCES)) u_data_ram (
      .clock(clock), .wr_en(data_we), .wr_addr(wr_addr), .wr_data(data_wd),
      .rd_addr(idx_ff[AW-1:0]), .rd_data(data_rd)
   );

   // a job is popped only with the result slot empty, so its result always fits
   assign job_pop = state_ff == S_IDLE && job_valid && !rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      used_in   = used_ff;
      job_in    = job_ff;
      key_we    = 1'b0;
      data_we   = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      key_wd    = {job_ff.ip, job_ff.port};
      data_wd   = data_rd;
      produce   = 1'b0;
      r_outcome = OUT_BAD_HDR;
      r_index   = '0;
      r_count   = '0;
      r_ptype   = '0;
      r_mc      = job.mc;
      r_first   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (job_pop) begin
               if (job.is_clear) begin
                  used_in = '0;
               end else if (!job.ok) begin
                  produce = 1'b1;
               end else if (job.mc && !allow_mc) begin
                  produce   = 1'b1;
                  r_outcome = OUT_MC_FILT;
               end else if (!job.mc && !allow_uc) begin
                  produce   = 1'b1;
                  r_outcome = OUT_UC_FILT;
               end else begin
                  job_in   = job;
                  idx_in   = '0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            r_mc = job_ff.mc;
            if (idx_ff == used_ff) begin
               produce  = 1'b1;
               state_in = S_IDLE;
               if (used_ff < SW'(MAX_SOURCES)) begin
                  key_we        = 1'b1;
                  data_we       = 1'b1;
                  data_wd.ptype = job_ff.ptype;
                  data_wd.mc    = job_ff.mc;
                  data_wd.count = COUNT_W'(1);
                  data_wd.first = job_ff.now;
                  used_in       = used_ff + SW'(1);
                  r_outcome     = OUT_NEW;
                  r_index       = idx_ff;
                  r_count       = COUNT_W'(1);
                  r_ptype       = job_ff.ptype;
                  r_first       = job_ff.now;
               end else begin
                  r_outcome = OUT_FULL;
               end
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            r_mc = job_ff.mc;
            if (key_rd == {job_ff.ip, job_ff.port}) begin
               data_we       = 1'b1;
               data_wd.count = (&data_rd.count) ? data_rd.count
                                                : data_rd.count + COUNT_W'(1);
               produce   = 1'b1;
               state_in  = S_IDLE;
               r_outcome = OUT_UPDATED;
               r_index   = idx_ff;
               r_count   = data_wd.count;
               r_ptype   = data_rd.ptype;
               r_mc      = data_rd.mc;
               r_first   = data_rd.first;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (produce) begin
         outcome_ff <= r_outcome;
         index_ff   <= ENTRY_W'(r_index);
         count_ff   <= r_count;
         ptype_ff   <= r_ptype;
         mc_ff      <= r_mc;
         first_ff   <= r_first;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         used_ff  <= used_in;
         if (produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.full = used_ff == SW'(MAX_SOURCES);
   assign status.busy = state_ff != S_IDLE;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.outcome       = outcome_ff;
   assign rsp.entry_index   = index_ff;
   assign rsp.source_count  = count_ff;
   assign rsp.rtp_type      = ptype_ff;
   assign rsp.is_multicast  = mc_ff;
   assign rsp.first_seen_ms = first_ff;
endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rtp_source_discovery_table_core: a directed table
// of packets, then random well-formed and broken RTP packets, all scored
// against a cycle-free model of the header check and source table.
// ----------------------------------------------------------------------------
module tb;
   import rsdt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_SRC   = 64;
   localparam int MAX_PKT = 2048;
   localparam int PKTS_PER_PHASE = 5;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [ENTRY_W-1:0]   idx;
      logic [COUNT_W-1:0]   count;
      logic [PT_W-1:0]      ptype;
      logic                 mc;
      logic [TIME_W-1:0]    first;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_ALLOW_MC;
   logic csr_wr_data = 1'b0;

   rsdt_req_if req_bus();
   rsdt_rsp_if rsp_bus();

   rtp_source_discovery_table_core #(.MAX_SOURCES(N_SRC), .MAX_PACKET_BYTES(MAX_PKT)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // model state
   logic        m_allow_mc, m_allow_uc;
   int unsigned m_len, m_need;
   logic        m_ver_ok, m_ext;
   logic [6:0]  m_ptype;
   logic [7:0]  m_ext_hi;
   int unsigned m_used;
   logic [31:0] t_ip [N_SRC];
   logic [15:0] t_port [N_SRC];
   logic [6:0]  t_type [N_SRC];
   logic        t_mc [N_SRC];
   logic [31:0] t_cnt [N_SRC];
   logic [63:0] t_first [N_SRC];

   verdict_type expected_q[$];
   // typed-in expectations for directed rows; checked in addition to the model
   verdict_type pinned_q[$];
   logic     pinned_on_q[$];
   int       errors = 0;
   longint   cycles = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   function automatic void parser_reset();
      m_len = 0; m_need = HDR_MIN; m_ver_ok = 0; m_ext = 0; m_ptype = 0; m_ext_hi = 0;
   endfunction

   function automatic void predict(input logic action, input logic [7:0] b, input logic last,
                                   input logic [31:0] ip, input logic [15:0] port,
                                   input logic [63:0] now);
      verdict_type v;
      logic ok, mc, hit;
      int k;
      if (action) begin
         m_used = 0;
         parser_reset();
         return;
      end
      if (m_len < MAX_PKT) begin
         if (m_len == 0) begin
            m_ver_ok = (b & VER_MASK) == VER_TWO;
            m_ext = b[4];
            m_need = HDR_MIN + b[3:0] * 4;
         end else if (m_len == 1) begin
            m_ptype = b[6:0];
         end
         if (m_len >= 2 && m_ext) begin
            if (m_len == m_need + 2) begin
               m_ext_hi = b;
            end else if (m_len == m_need + 3) begin
               m_need += 4 + {m_ext_hi, b} * 4;
               m_ext = 0;
            end
         end
         m_len++;
      end
      if (!last) return;
      v = '0;
      ok = m_ver_ok && m_len >= HDR_MIN && !m_ext && m_need <= m_len;
      mc = ip[31:28] == MC_PREFIX;
      v.mc = mc;
      if (!ok) v.outcome = OUT_BAD_HDR;
      else if (mc && !m_allow_mc) v.outcome = OUT_MC_FILT;
      else if (!mc && !m_allow_uc) v.outcome = OUT_UC_FILT;
      else begin
         hit = 0;
         k = 0;
         for (int i = 0; i < m_used; i++)
            if (!hit && t_ip[i] == ip && t_port[i] == port) begin
               hit = 1; k = i;
            end
         if (hit) begin
            if (t_cnt[k] != '1) t_cnt[k]++;
            v.outcome = OUT_UPDATED;
         end else if (m_used < N_SRC) begin
            k = m_used;
            t_ip[k] = ip; t_port[k] = port; t_type[k] = m_ptype; t_mc[k] = mc;
            t_cnt[k] = 1; t_first[k] = now;
            m_used++;
            v.outcome = OUT_NEW;
         end else v.outcome = OUT_FULL;
         if (v.outcome == OUT_NEW || v.outcome == OUT_UPDATED) begin
            v.idx = ENTRY_W'(k); v.count = t_cnt[k]; v.ptype = t_type[k];
            v.mc = t_mc[k]; v.first = t_first[k];
         end
      end
      parser_reset();
      expected_q = {expected_q, v};
   endfunction

   // sender burst/gap state
   int burst_left = 0, gap_left = 0;
   logic no_idle = 0;

   task automatic send(input logic action, input logic [7:0] b, input logic last,
                       input logic [31:0] ip, input logic [15:0] port, input logic [63:0] now);
      while (!no_idle && gap_left > 0) begin
         req_bus.valid <= 1'b0;
         gap_left--;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= action;
      req_bus.packet_byte <= b;
      req_bus.last_byte <= last;
      req_bus.source_ip <= ip;
      req_bus.listen_port <= port;
      req_bus.now_ms <= now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict(action, b, last, ip, port, now);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(40, 1);
         gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      end
   endtask

   task automatic idle_bus();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // packet: 12+csrc*4 header, optional extension of ext_words, payload bytes
   task automatic send_packet(input logic [7:0] b0, input logic [6:0] pt, input int csrc,
                              input logic ext, input int ext_words, input int payload,
                              input int cut, input logic [31:0] ip, input logic [15:0] port,
                              input logic [63:0] now);
      int n, hl;
      logic [7:0] b;
      hl = 12 + csrc * 4;
      n = hl + (ext ? 4 + ext_words * 4 : 0) + payload;
      if (cut > 0 && cut < n) n = cut;
      if (n < 1) n = 1;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         if (i == 0) b = b0;
         else if (i == 1) b = {b[7], pt};
         else if (ext && i == hl + 2) b = ext_words[15:8];
         else if (ext && i == hl + 3) b = ext_words[7:0];
         send(1'b0, b, i == n - 1, ip, port, now);
      end
   endtask

   function automatic logic [7:0] hdr0(input int csrc, input logic ext);
      logic [7:0] b;
      b = 8'($urandom);
      return {2'b10, b[5], ext, csrc[3:0]};
   endfunction

   task automatic drain();
      int quiet = 0;
      req_bus.valid <= 1'b0;
      while (expected_q.size() > 0) @(posedge clock);
      while (quiet < 2 * N_SRC * 2 + 20) begin
         @(posedge clock);
         quiet++;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_ALLOW_MC) m_allow_mc = val; else m_allow_uc = val;
      @(posedge clock);
   endtask

   // receiver: stall pattern with its own period
   logic [15:0] stall_pat;
   logic no_stall = 0;
   initial stall_pat = 16'b0110_0010_1110_0001;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (cycles % 512 == 0) stall_pat <= 16'($urandom);
         rsp_bus.ready <= no_stall || !stall_pat[cycles % 16] || ($urandom_range(3) == 0);
      end
   end

   // scoreboard
   always @(posedge clock) begin
      verdict_type w, got;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.outcome, rsp_bus.entry_index, rsp_bus.source_count,
                 rsp_bus.rtp_type, rsp_bus.is_multicast, rsp_bus.first_seen_ms};
         if (expected_q.size() == 0) report("unexpected transaction", got.outcome, 0);
         else begin
            w = expected_q.pop_front();
            if (got.outcome != w.outcome) report("outcome", got.outcome, w.outcome);
            if (got.idx != w.idx) report("entry_index", got.idx, w.idx);
            if (got.count != w.count) report("source_count", got.count, w.count);
            if (got.ptype != w.ptype) report("rtp_type", got.ptype, w.ptype);
            if (got.mc != w.mc) report("is_multicast", got.mc, w.mc);
            if (got.first != w.first) report("first_seen_ms", got.first, w.first);
            if (pinned_on_q.size() > 0) begin
               if (pinned_on_q.pop_front() && got != pinned_q[0])
                  report("pinned row", got.outcome, pinned_q[0].outcome);
               void'(pinned_q.pop_front());
            end
         end
      end
   end

   // directed table
   typedef struct {
      logic [7:0]  b0;
      logic [6:0]  pt;
      int          csrc;
      logic        ext;
      int          ext_words;
      int          payload;
      int          cut;
      logic [31:0] ip;
      logic [15:0] port;
      logic [63:0] now;
      logic        pin;
      verdict_type want;
   } row_type;

   row_type rows[$];

   function automatic row_type mk(input logic [7:0] b0, input logic [6:0] pt, input int csrc,
                                  input logic ext, input int ew, input int pl, input int cut,
                                  input logic [31:0] ip, input logic [15:0] port,
                                  input logic [63:0] now, input logic pin,
                                  input verdict_type want);
      row_type r;
      r.b0 = b0; r.pt = pt; r.csrc = csrc; r.ext = ext; r.ext_words = ew; r.payload = pl;
      r.cut = cut; r.ip = ip; r.port = port; r.now = now; r.pin = pin; r.want = want;
      return r;
   endfunction

   initial begin
      logic [31:0] ips [8];
      logic [15:0] ports [4];
      logic [31:0] ip;
      int kind, csrc;
      logic ext;
      req_bus.valid = 1'b0;
      req_bus.action = 1'b0;
      req_bus.packet_byte = '0;
      req_bus.last_byte = 1'b0;
      req_bus.source_ip = '0;
      req_bus.listen_port = '0;
      req_bus.now_ms = '0;
      m_allow_mc = 1; m_allow_uc = 1; m_used = 0;
      parser_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = {rows, mk(8'h80, 7'h00, 0, 0, 0, 0, 0, 32'h0A000001, 16'd5004, 64'd100, 1,
                       '{OUT_NEW, 6'd0, 32'd1, 7'h00, 1'b0, 64'd100})};
      rows = {rows, mk(8'h80, 7'h7F, 0, 0, 0, 5, 0, 32'h0A000001, 16'd5004, 64'd200, 1,
                       '{OUT_UPDATED, 6'd0, 32'd2, 7'h00, 1'b0, 64'd100})};
      rows = {rows, mk(8'hBF, 7'h7F, 15, 1, 65535, 0, 11, 32'hFFFFFFFF, 16'hFFFF, '1, 1,
                       '{OUT_BAD_HDR, 6'd0, 32'd0, 7'h00, 1'b0, 64'd0})};
      rows = {rows, mk(8'h40, 7'h11, 0, 0, 0, 3, 0, 32'hE0000000, 16'd1, 64'd1, 1,
                       '{OUT_BAD_HDR, 6'd0, 32'd0, 7'h00, 1'b1, 64'd0})};
      rows = {rows, mk(8'h83, 7'h11, 3, 0, 0, 0, 20, 32'h01020304, 16'd1, 64'd1, 1,
                       '{OUT_BAD_HDR, 6'd0, 32'd0, 7'h00, 1'b0, 64'd0})};
      // extension cut before its length bytes arrive
      rows = {rows, mk(8'h90, 7'h11, 0, 1, 0, 0, 14, 32'h01020304, 16'd1, 64'd1, 1,
                       '{OUT_BAD_HDR, 6'd0, 32'd0, 7'h00, 1'b0, 64'd0})};
      rows = {rows, mk(8'h90, 7'h21, 0, 1, 2, 4, 0, 32'hEFFFFFFF, 16'd0, '1, 0, '0)};
      rows = {rows, mk(8'h92, 7'h22, 2, 1, 3, 0, 0, 32'hDFFFFFFF, 16'd7, 64'd9, 0, '0)};
      rows = {rows, mk(8'h91, 7'h23, 1, 1, 5, 0, 30, 32'hF0000000, 16'd7, 64'd9, 0, '0)};
      rows = {rows, mk(8'hAF, 7'h24, 15, 0, 0, 2, 0, 32'h00000000, 16'd0, 64'd0, 0, '0)};
      // extension far longer than the packet
      rows = {rows, mk(8'h90, 7'h26, 0, 1, 600, 0, 40, 32'h0A000003, 16'd9, 64'd5, 0, '0)};
      rows = {rows, mk(8'h80, 7'h27, 0, 0, 0, 0, 0, 32'h0A000001, 16'd5005, 64'd7, 0, '0)};
      foreach (rows[i]) begin
         pinned_on_q = {pinned_on_q, rows[i].pin};
         pinned_q = {pinned_q, rows[i].want};
         send_packet(rows[i].b0, rows[i].pt, rows[i].csrc, rows[i].ext, rows[i].ext_words,
                     rows[i].payload, rows[i].cut, rows[i].ip, rows[i].port, rows[i].now);
      end
      // clear in the middle of a packet
      send(1'b0, 8'h80, 1'b0, 0, 0, 0);
      send(1'b1, 8'hFF, 1'b1, '1, '1, '1);
      send_packet(8'h80, 7'h33, 0, 0, 0, 0, 0, 32'h0A000009, 16'd1, 64'd77);
      drain();
      pinned_on_q.delete();
      pinned_q.delete();

      // filter settings, extremes
      write_reg(REG_ALLOW_MC, 1'b0);
      write_reg(REG_ALLOW_UC, 1'b0);
      send_packet(8'h80, 7'h1, 0, 0, 0, 0, 0, 32'hE1000000, 16'd1, 64'd1);
      send_packet(8'h80, 7'h1, 0, 0, 0, 0, 0, 32'h0A000009, 16'd1, 64'd1);
      drain();
      write_reg(REG_ALLOW_MC, 1'b1);
      write_reg(REG_ALLOW_UC, 1'b1);

      // random phases, each with its own filter setting
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 8; i++) ips[i] = $urandom;
         ips[0][31:28] = MC_PREFIX;
         ips[1][31:28] = 4'hD;
         for (int i = 0; i < 4; i++) ports[i] = 16'($urandom);
         no_idle = (ph == 2);
         no_stall = (ph == 3);
         for (int p = 0; p < PKTS_PER_PHASE; p++) begin
            kind = $urandom_range(99);
            csrc = ($urandom_range(3) == 0) ? $urandom_range(15) : 0;
            ext = $urandom_range(2) == 0;
            ip = ($urandom_range(4) == 0) ? $urandom : ips[$urandom_range(7)];
            if (kind < 3) begin
               send(1'b1, 8'($urandom), 1'($urandom), $urandom, 16'($urandom),
                    {$urandom, $urandom});
            end else if (kind < 80) begin
               send_packet(hdr0(csrc, ext), 7'($urandom), csrc, ext, $urandom_range(3),
                           $urandom_range(6), 0, ip, ports[$urandom_range(3)],
                           {$urandom, $urandom});
            end else begin
               send_packet(8'($urandom), 7'($urandom), csrc, ext, $urandom_range(3),
                           $urandom_range(6), $urandom_range(20), ip,
                           ports[$urandom_range(3)], {$urandom, $urandom});
            end
         end
         // fill the table up to full
         if (ph == 4)
            for (int i = 0; i < N_SRC + 3; i++)
               send_packet(8'h80, 7'($urandom), 0, 0, 0, 0, 0, $urandom, 16'(i),
                           {$urandom, $urandom});
         drain();
         write_reg(REG_ALLOW_MC, $urandom_range(2) != 0);
         write_reg(REG_ALLOW_UC, $urandom_range(2) != 0);
      end
      drain();
      if (errors == 0 && expected_q.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule
